>>> hw/rtl/sorted_keyed_record_list_defines.svh
// assertion macros for the sorted keyed record list checker
`ifndef SORTED_KEYED_RECORD_LIST_DEFINES_SVH
`define SORTED_KEYED_RECORD_LIST_DEFINES_SVH

// same-cycle implication, disabled in reset
`define SKL_ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("sorted keyed record list check failed");

// next-cycle implication, disabled in reset
`define SKL_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("sorted keyed record list check failed");

`endif

>>> hw/rtl/skl_pkg.sv
// shared types and constants of the sorted keyed record list
package skl_pkg;

  localparam int SKL_CAPACITY = 16;

  localparam int KEY_W     = 16;
  localparam int VAL_W     = 32;
  localparam int CMD_W     = 2;
  localparam int STAT_W    = 2;
  localparam int CNT_OUT_W = 5;

  localparam logic [CMD_W-1:0] CMD_INSERT = 2'd0;
  localparam logic [CMD_W-1:0] CMD_REMOVE = 2'd1;
  localparam logic [CMD_W-1:0] CMD_NEXT   = 2'd2;

  localparam logic [STAT_W-1:0] STAT_DONE = 2'd0;
  localparam logic [STAT_W-1:0] STAT_MISS = 2'd1;
  localparam logic [STAT_W-1:0] STAT_FULL = 2'd2;

  localparam logic signed [KEY_W-1:0] SENT_YEAR = -16'sd99;
  localparam logic signed [VAL_W-1:0] SENT_FLOW = -32'sd6488064;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DISPATCH,
    S_SRCH_RD,
    S_SRCH_CHK,
    S_DECIDE,
    S_UP_RD,
    S_UP_WR,
    S_DN_RD,
    S_DN_WR,
    S_NEXT_RD,
    S_NEXT_OUT
  } skl_state_t;

  typedef enum logic [4:0] {
    DP_NOP,
    DP_LOAD,
    DP_SRCH_RD,
    DP_SRCH_STEP,
    DP_SET_HIT,
    DP_SET_MISS,
    DP_UP_INIT,
    DP_UP_RD,
    DP_UP_WR,
    DP_INS_WRITE,
    DP_DN_INIT,
    DP_DN_RD,
    DP_DN_WR,
    DP_REM_FIN,
    DP_NEXT_RD,
    DP_NEXT_OUT,
    DP_FIN_OK,
    DP_FIN_MISS,
    DP_FIN_FULL
  } skl_dp_op_t;

  typedef struct packed {
    logic [CMD_W-1:0] op;
    logic             at_count;
    logic             key_lt;
    logic             hit;
    logic             full;
    logic             up_done;
    logic             dn_done;
  } skl_stat_t;

endpackage

>>> hw/rtl/skl_datapath.sv
// record memories, count, cursor and result registers of the record list
module skl_datapath import skl_pkg::*; #(
  parameter int CAPACITY = SKL_CAPACITY
) (
  input  logic                     clk,
  input  logic                     rst,
  input  skl_dp_op_t               dp_op,
  output skl_stat_t                stat,
  input  logic [CMD_W-1:0]         cmd,
  input  logic signed [KEY_W-1:0]  key_year,
  input  logic signed [VAL_W-1:0]  flow_value,
  output logic                     done,
  output logic [STAT_W-1:0]        status,
  output logic signed [KEY_W-1:0]  out_year,
  output logic signed [VAL_W-1:0]  out_flow,
  output logic                     at_end,
  output logic [CNT_OUT_W-1:0]     record_count
);

  localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW = $clog2(CAPACITY + 1);
  localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);

  logic signed [KEY_W-1:0] key_mem [CAPACITY];
  logic signed [VAL_W-1:0] val_mem [CAPACITY];

  logic [CMD_W-1:0]        op_q;
  logic signed [KEY_W-1:0] key_q;
  logic signed [VAL_W-1:0] val_q;
  logic [CW-1:0]           pos;
  logic [CW-1:0]           p;
  logic                    hit;
  logic [CW-1:0]           nx;
  logic                    nx_ok;
  logic [CW-1:0]           count;
  logic [CW-1:0]           cursor;
  logic signed [KEY_W-1:0] rkey;
  logic signed [VAL_W-1:0] rval;

  logic [CW-1:0]           count_next;
  logic [CW-1:0]           cursor_next;
  logic [CW-1:0]           pos_inc;
  logic [CW-1:0]           pos_dec;
  logic [CW-1:0]           nx_c;
  logic                    we;
  logic                    re;
  logic [CW-1:0]           waddr;
  logic [CW-1:0]           raddr;
  logic signed [KEY_W-1:0] wkey;
  logic signed [VAL_W-1:0] wval;
  logic                    fin;
  logic [STAT_W-1:0]       res_status;
  logic signed [KEY_W-1:0] res_year;
  logic signed [VAL_W-1:0] res_flow;
  logic                    res_end;

  assign pos_inc = pos + 1'b1;
  assign pos_dec = pos - 1'b1;
  assign nx_c    = (cursor == CAP_C) ? '0 : cursor + 1'b1;

  always_comb begin
    stat.op       = op_q;
    stat.at_count = (pos == count);
    stat.key_lt   = (rkey < key_q);
    stat.hit      = hit;
    stat.full     = (count == CAP_C);
    stat.up_done  = (pos == p);
    stat.dn_done  = (pos_inc >= count);
  end

  // memory port control
  always_comb begin
    we    = 1'b0;
    re    = 1'b0;
    waddr = pos;
    raddr = pos;
    wkey  = rkey;
    wval  = rval;
    case (dp_op)
      DP_SRCH_RD: begin
        re = 1'b1;
      end
      DP_UP_RD: begin
        re    = 1'b1;
        raddr = pos_dec;
      end
      DP_UP_WR: begin
        we = 1'b1;
      end
      DP_INS_WRITE: begin
        we    = 1'b1;
        waddr = p;
        wkey  = key_q;
        wval  = val_q;
      end
      DP_DN_RD: begin
        re    = 1'b1;
        raddr = pos_inc;
      end
      DP_DN_WR: begin
        we = 1'b1;
      end
      DP_NEXT_RD: begin
        re    = (nx_c < count);
        raddr = nx_c;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (we) begin
      key_mem[waddr[AW-1:0]] <= wkey;
      val_mem[waddr[AW-1:0]] <= wval;
    end
    if (re) begin
      rkey <= key_mem[raddr[AW-1:0]];
      rval <= val_mem[raddr[AW-1:0]];
    end
  end

  // count and cursor updates
  always_comb begin
    count_next  = count;
    cursor_next = cursor;
    case (dp_op)
      DP_INS_WRITE: begin
        count_next = count + 1'b1;
        if (cursor != CAP_C && p <= cursor) begin
          cursor_next = cursor + 1'b1;
        end
      end
      DP_REM_FIN: begin
        count_next = count - 1'b1;
        if (cursor != CAP_C) begin
          if (cursor == p) begin
            cursor_next = CAP_C;
          end else if (p < cursor) begin
            cursor_next = cursor - 1'b1;
          end
        end
      end
      DP_NEXT_OUT: begin
        cursor_next = nx_ok ? nx : CAP_C;
      end
      default: begin
      end
    endcase
  end

  // result of a finishing step
  always_comb begin
    fin        = 1'b0;
    res_status = STAT_DONE;
    res_year   = '0;
    res_flow   = '0;
    res_end    = 1'b0;
    case (dp_op)
      DP_INS_WRITE, DP_REM_FIN, DP_FIN_OK: begin
        fin = 1'b1;
      end
      DP_FIN_MISS: begin
        fin        = 1'b1;
        res_status = STAT_MISS;
      end
      DP_FIN_FULL: begin
        fin        = 1'b1;
        res_status = STAT_FULL;
      end
      DP_NEXT_OUT: begin
        fin = 1'b1;
        if (nx_ok) begin
          res_year = rkey;
          res_flow = rval;
        end else begin
          res_year = SENT_YEAR;
          res_flow = SENT_FLOW;
          res_end  = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count  <= '0;
      cursor <= CAP_C;
      done   <= 1'b0;
    end else begin
      count  <= count_next;
      cursor <= cursor_next;
      done   <= fin;
    end
  end

  always_ff @(posedge clk) begin
    if (fin) begin
      status       <= res_status;
      out_year     <= res_year;
      out_flow     <= res_flow;
      at_end       <= res_end;
      record_count <= CNT_OUT_W'(count_next);
    end
  end

  // working registers of the transaction
  always_ff @(posedge clk) begin
    case (dp_op)
      DP_LOAD: begin
        op_q  <= cmd;
        key_q <= key_year;
        val_q <= flow_value;
        pos   <= '0;
      end
      DP_SRCH_STEP: begin
        pos <= pos_inc;
      end
      DP_SET_HIT: begin
        p   <= pos;
        hit <= (rkey == key_q);
      end
      DP_SET_MISS: begin
        p   <= pos;
        hit <= 1'b0;
      end
      DP_UP_INIT: begin
        pos <= count;
      end
      DP_UP_WR: begin
        pos <= pos_dec;
      end
      DP_DN_INIT: begin
        pos <= p;
      end
      DP_DN_WR: begin
        pos <= pos_inc;
      end
      DP_NEXT_RD: begin
        nx    <= nx_c;
        nx_ok <= (nx_c < count);
      end
      default: begin
      end
    endcase
  end

endmodule

>>> hw/rtl/skl_controller.sv
// state machine that sequences search, shift and read steps
module skl_controller import skl_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       start,
  input  skl_stat_t  stat,
  output logic       busy,
  output skl_dp_op_t dp_op
);

  skl_state_t state;
  skl_state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (start) begin
          state_next = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        if (stat.op == CMD_INSERT || stat.op == CMD_REMOVE) begin
          state_next = S_SRCH_RD;
        end else if (stat.op == CMD_NEXT) begin
          state_next = S_NEXT_RD;
        end else begin
          state_next = S_IDLE;
        end
      end
      S_SRCH_RD: begin
        state_next = stat.at_count ? S_DECIDE : S_SRCH_CHK;
      end
      S_SRCH_CHK: begin
        state_next = stat.key_lt ? S_SRCH_RD : S_DECIDE;
      end
      S_DECIDE: begin
        if (stat.op == CMD_INSERT) begin
          state_next = (stat.hit || stat.full) ? S_IDLE : S_UP_RD;
        end else begin
          state_next = stat.hit ? S_DN_RD : S_IDLE;
        end
      end
      S_UP_RD: begin
        state_next = stat.up_done ? S_IDLE : S_UP_WR;
      end
      S_UP_WR: begin
        state_next = S_UP_RD;
      end
      S_DN_RD: begin
        state_next = stat.dn_done ? S_IDLE : S_DN_WR;
      end
      S_DN_WR: begin
        state_next = S_DN_RD;
      end
      S_NEXT_RD: begin
        state_next = S_NEXT_OUT;
      end
      S_NEXT_OUT: begin
        state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_comb begin
    dp_op = DP_NOP;
    busy  = (state != S_IDLE);
    case (state)
      S_IDLE: begin
        if (start) begin
          dp_op = DP_LOAD;
        end
      end
      S_DISPATCH: begin
        if (stat.op != CMD_INSERT && stat.op != CMD_REMOVE && stat.op != CMD_NEXT) begin
          dp_op = DP_FIN_OK;
        end
      end
      S_SRCH_RD: begin
        dp_op = stat.at_count ? DP_SET_MISS : DP_SRCH_RD;
      end
      S_SRCH_CHK: begin
        dp_op = stat.key_lt ? DP_SRCH_STEP : DP_SET_HIT;
      end
      S_DECIDE: begin
        if (stat.op == CMD_INSERT) begin
          if (stat.hit) begin
            dp_op = DP_FIN_MISS;
          end else if (stat.full) begin
            dp_op = DP_FIN_FULL;
          end else begin
            dp_op = DP_UP_INIT;
          end
        end else begin
          dp_op = stat.hit ? DP_DN_INIT : DP_FIN_MISS;
        end
      end
      S_UP_RD: begin
        dp_op = stat.up_done ? DP_INS_WRITE : DP_UP_RD;
      end
      S_UP_WR: begin
        dp_op = DP_UP_WR;
      end
      S_DN_RD: begin
        dp_op = stat.dn_done ? DP_REM_FIN : DP_DN_RD;
      end
      S_DN_WR: begin
        dp_op = DP_DN_WR;
      end
      S_NEXT_RD: begin
        dp_op = DP_NEXT_RD;
      end
      S_NEXT_OUT: begin
        dp_op = DP_NEXT_OUT;
      end
      default: begin
      end
    endcase
  end

endmodule

>>> hw/rtl/sorted_keyed_record_list.sv
// top level of the sorted keyed record list
//
// Holds up to CAPACITY records (16-bit signed key, Q16.16 value) sorted by
// ascending key in a pair of single-port-style memories.
// A transaction is accepted at a rising edge with start high and busy low;
// cmd, key_year and flow_value are sampled there. busy stays high until the
// transaction has finished. Its result is on status, out_year, out_flow,
// at_end and record_count, marked by done, which is high for exactly one
// cycle and cannot be held off; the result outputs keep their values until
// the next transaction finishes.
// Next reads the record after the cursor, or gives the end sentinel; an
// unused command finishes straight from dispatch. Insert and remove scan
// the records one at a time (a memory read, then a compare) and then move
// the records behind the slot one at a time (a read, then a write).
// One transaction is in flight at a time; the next one can be accepted in
// the cycle that carries done.
// Reset (synchronous, rst high) empties the list and puts the read cursor
// before the first record; the record memories are not cleared.
module sorted_keyed_record_list import skl_pkg::*; #(
  parameter int CAPACITY = SKL_CAPACITY
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     start,
  output logic                     busy,
  input  logic [CMD_W-1:0]         cmd,
  input  logic signed [KEY_W-1:0]  key_year,
  input  logic signed [VAL_W-1:0]  flow_value,
  output logic                     done,
  output logic [STAT_W-1:0]        status,
  output logic signed [KEY_W-1:0]  out_year,
  output logic signed [VAL_W-1:0]  out_flow,
  output logic                     at_end,
  output logic [CNT_OUT_W-1:0]     record_count
);

  skl_dp_op_t dp_op;
  skl_stat_t  stat;

  skl_controller u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .stat  (stat),
    .busy  (busy),
    .dp_op (dp_op)
  );

  skl_datapath #(
    .CAPACITY (CAPACITY)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .dp_op        (dp_op),
    .stat         (stat),
    .cmd          (cmd),
    .key_year     (key_year),
    .flow_value   (flow_value),
    .done         (done),
    .status       (status),
    .out_year     (out_year),
    .out_flow     (out_flow),
    .at_end       (at_end),
    .record_count (record_count)
  );

endmodule

>>> hw/rtl/skl_checker.sv
// port-level checks of the sorted keyed record list and their binding
`include "sorted_keyed_record_list_defines.svh"

module skl_checker import skl_pkg::*; #(
  parameter int CAPACITY = SKL_CAPACITY
) (
  input logic                    clk,
  input logic                    rst,
  input logic                    start,
  input logic                    busy,
  input logic                    done,
  input logic [STAT_W-1:0]       status,
  input logic signed [KEY_W-1:0] out_year,
  input logic signed [VAL_W-1:0] out_flow,
  input logic                    at_end,
  input logic [CNT_OUT_W-1:0]    record_count
);

  localparam logic [CNT_OUT_W-1:0] CAP_COUNT = CNT_OUT_W'(CAPACITY);

  logic sent_ok;

  assign sent_ok = (out_year == SENT_YEAR) && (out_flow == SENT_FLOW) && (status == STAT_DONE);

  `SKL_ASSERT_IMP(a_done_idle, clk, rst, done, !busy)
  `SKL_ASSERT_NEXT(a_accept_busy, clk, rst, start && !busy, busy)
  `SKL_ASSERT_IMP(a_end_sentinel, clk, rst, done && at_end, sent_ok)
  `SKL_ASSERT_IMP(a_full_count, clk, rst, done && status == STAT_FULL, record_count == CAP_COUNT)

endmodule

bind sorted_keyed_record_list skl_checker #(.CAPACITY(CAPACITY)) u_skl_checker (.*);

>>> verif/record_list_checker.sv
`timescale 1ns / 1ps
// checker that predicts and compares every result of the sorted keyed record list
module record_list_checker import skl_pkg::*; (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    start,
  input  logic                    busy,
  input  logic [CMD_W-1:0]        cmd,
  input  logic signed [KEY_W-1:0] key_year,
  input  logic signed [VAL_W-1:0] flow_value,
  input  logic                    done,
  input  logic [STAT_W-1:0]       status,
  input  logic signed [KEY_W-1:0] out_year,
  input  logic signed [VAL_W-1:0] out_flow,
  input  logic                    at_end,
  input  logic [CNT_OUT_W-1:0]    record_count,
  output int                      mismatch_count,
  output int                      pending_count
);

  typedef struct packed {
    logic [STAT_W-1:0]        status;
    logic signed [KEY_W-1:0]  year;
    logic signed [VAL_W-1:0]  flow;
    logic                     at_end;
    logic [CNT_OUT_W-1:0]     count;
  } list_result_t;

  logic signed [KEY_W-1:0] shadow_keys [SKL_CAPACITY];
  logic signed [VAL_W-1:0] shadow_flows [SKL_CAPACITY];
  int                      shadow_count;
  int                      read_pos;
  int                      fails;
  list_result_t            expected_results [$];

  function automatic int slot_for(logic signed [KEY_W-1:0] k);
    int i;
    i = 0;
    while (i < shadow_count && shadow_keys[i] < k) i++;
    return i;
  endfunction

  task automatic apply_command(input logic [CMD_W-1:0] c, input logic signed [KEY_W-1:0] k,
                               input logic signed [VAL_W-1:0] v, output list_result_t r);
    int p;
    int nx;
    r = '0;
    case (c)
      CMD_INSERT: begin
        p = slot_for(k);
        if (p < shadow_count && shadow_keys[p] == k) begin
          r.status = STAT_MISS;
        end else if (shadow_count >= SKL_CAPACITY) begin
          r.status = STAT_FULL;
        end else begin
          for (int i = shadow_count; i > p; i--) begin
            shadow_keys[i] = shadow_keys[i-1];
            shadow_flows[i] = shadow_flows[i-1];
          end
          shadow_keys[p] = k;
          shadow_flows[p] = v;
          shadow_count++;
          if (read_pos < SKL_CAPACITY && p <= read_pos) read_pos++;
          r.status = STAT_DONE;
        end
      end
      CMD_REMOVE: begin
        p = slot_for(k);
        if (p < shadow_count && shadow_keys[p] == k) begin
          for (int i = p; i + 1 < shadow_count; i++) begin
            shadow_keys[i] = shadow_keys[i+1];
            shadow_flows[i] = shadow_flows[i+1];
          end
          shadow_count--;
          if (read_pos < SKL_CAPACITY) begin
            if (read_pos == p) read_pos = SKL_CAPACITY;
            else if (p < read_pos) read_pos--;
          end
          r.status = STAT_DONE;
        end else begin
          r.status = STAT_MISS;
        end
      end
      CMD_NEXT: begin
        nx = (read_pos >= SKL_CAPACITY) ? 0 : read_pos + 1;
        if (nx < shadow_count) begin
          read_pos = nx;
          r.year = shadow_keys[nx];
          r.flow = shadow_flows[nx];
        end else begin
          read_pos = SKL_CAPACITY;
          r.year = SENT_YEAR;
          r.flow = SENT_FLOW;
          r.at_end = 1'b1;
        end
      end
      default: ;
    endcase
    r.count = shadow_count[CNT_OUT_W-1:0];
  endtask

  function automatic int field_bad(string name, longint exp_val, longint act_val);
    if (exp_val != act_val) begin
      $error("%s: expected %0d, actual %0d", name, exp_val, act_val);
      return 1;
    end
    return 0;
  endfunction

  always @(posedge clk) begin
    list_result_t exp_r;
    list_result_t new_r;
    if (rst) begin
      shadow_count = 0;
      read_pos = SKL_CAPACITY;
      fails = 0;
      expected_results.delete();
    end else begin
      if (done) begin
        if (expected_results.size() == 0) begin
          $error("result with no transaction outstanding");
          fails++;
        end else begin
          exp_r = expected_results.pop_front();
          fails += field_bad("status", exp_r.status, status);
          fails += field_bad("out_year", exp_r.year, out_year);
          fails += field_bad("out_flow", exp_r.flow, out_flow);
          fails += field_bad("at_end", exp_r.at_end, at_end);
          fails += field_bad("record_count", exp_r.count, record_count);
        end
      end
      if (start && !busy) begin
        apply_command(cmd, key_year, flow_value, new_r);
        expected_results.push_back(new_r);
      end
    end
    mismatch_count <= fails;
    pending_count <= expected_results.size();
  end

endmodule

>>> verif/tb_sorted_keyed_record_list.sv
`timescale 1ns / 1ps
// testbench top: drives commands into the sorted keyed record list and gives the verdict
module tb_sorted_keyed_record_list import skl_pkg::*;;

  localparam logic [CMD_W-1:0] CMD_NOP = 2'd3;
  localparam int RANDOM_ITEMS = 950;

  logic                    clk;
  logic                    rst;
  logic                    start;
  logic                    busy;
  logic [CMD_W-1:0]        cmd;
  logic signed [KEY_W-1:0] key_year;
  logic signed [VAL_W-1:0] flow_value;
  logic                    done;
  logic [STAT_W-1:0]       status;
  logic signed [KEY_W-1:0] out_year;
  logic signed [VAL_W-1:0] out_flow;
  logic                    at_end;
  logic [CNT_OUT_W-1:0]    record_count;
  int                      mismatch_count;
  int                      pending_count;

  sorted_keyed_record_list DUT (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .cmd(cmd),
    .key_year(key_year), .flow_value(flow_value), .done(done), .status(status),
    .out_year(out_year), .out_flow(out_flow), .at_end(at_end),
    .record_count(record_count)
  );

  record_list_checker u_checker (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .cmd(cmd),
    .key_year(key_year), .flow_value(flow_value), .done(done), .status(status),
    .out_year(out_year), .out_flow(out_flow), .at_end(at_end),
    .record_count(record_count), .mismatch_count(mismatch_count),
    .pending_count(pending_count)
  );

  initial clk = 1'b0;
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  task automatic send_transaction(input logic [CMD_W-1:0] c, input logic signed [KEY_W-1:0] k,
                                  input logic signed [VAL_W-1:0] v);
    start <= 1'b1;
    cmd <= c;
    key_year <= k;
    flow_value <= v;
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  task automatic idle_sender(input int cycles);
    start <= 1'b0;
    repeat (cycles) @(posedge clk);
  endtask

  initial begin
    #5_000_000;
    $display("sorted_keyed_record_list test failed");
    $finish;
  end

  initial begin
    int sent;
    int phase_len;
    int ins_w;
    int rem_w;
    int pool;
    int roll;
    bit idle_on;
    logic [CMD_W-1:0] c;
    logic signed [KEY_W-1:0] base;
    logic signed [KEY_W-1:0] k;
    start = 1'b0;
    cmd = CMD_INSERT;
    key_year = '0;
    flow_value = '0;
    rst = 1'b1;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed part
    send_transaction(CMD_NEXT, 16'sd0, 32'sd0);
    send_transaction(CMD_INSERT, 16'sh7FFF, 32'sh7FFFFFFF);
    send_transaction(CMD_INSERT, -16'sh8000, -32'sh80000000);
    send_transaction(CMD_INSERT, 16'sd0, 32'sd65536);
    send_transaction(CMD_INSERT, 16'sh7FFF, 32'sd1);
    send_transaction(CMD_REMOVE, 16'sd5, 32'sd0);
    send_transaction(CMD_NEXT, 16'sd0, 32'sd0);
    idle_sender(3);
    send_transaction(CMD_NEXT, -16'sd1, -32'sd1);
    send_transaction(CMD_INSERT, -16'sd5, 32'sh0001_8000);
    send_transaction(CMD_REMOVE, -16'sh8000, 32'sd0);
    send_transaction(CMD_REMOVE, 16'sd0, 32'sd0);
    send_transaction(CMD_NEXT, 16'sd0, 32'sd0);
    send_transaction(CMD_NEXT, 16'sd0, 32'sd0);
    send_transaction(CMD_NEXT, 16'sd0, 32'sd0);
    send_transaction(CMD_NOP, -16'sd1, -32'sd1);
    for (int i = 0; i < SKL_CAPACITY - 2; i++)
      send_transaction(CMD_INSERT, 16'(1000 - 100 * i), $urandom);
    send_transaction(CMD_INSERT, 16'sd7, 32'sd7);
    send_transaction(CMD_INSERT, -16'sd5, 32'sd7);

    // random part: phases that fill, drain or churn the table
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      phase_len = $urandom_range(40, 80);
      case ($urandom_range(0, 2))
        0: ins_w = 70;
        1: ins_w = 25;
        default: ins_w = 45;
      endcase
      rem_w = 80 - ins_w;
      pool = $urandom_range(4, 30);
      base = KEY_W'($urandom_range(0, 65535));
      idle_on = ($urandom_range(0, 2) != 0) && (sent < RANDOM_ITEMS - 100);
      for (int n = 0; n < phase_len && sent < RANDOM_ITEMS; n++) begin
        roll = $urandom_range(0, 99);
        if (roll < ins_w) c = CMD_INSERT;
        else if (roll < ins_w + rem_w) c = CMD_REMOVE;
        else if (roll < 97) c = CMD_NEXT;
        else c = CMD_NOP;
        roll = $urandom_range(0, 99);
        if (roll < 85) k = base + KEY_W'($urandom_range(0, pool - 1));
        else if (roll < 90) k = -16'sh8000;
        else if (roll < 95) k = 16'sh7FFF;
        else k = KEY_W'($urandom);
        if (idle_on && sent < RANDOM_ITEMS - 100 && $urandom_range(0, 3) == 0)
          idle_sender($urandom_range(1, 18));
        send_transaction(c, k, $urandom);
        sent++;
      end
    end

    start <= 1'b0;
    @(posedge clk);
    while (pending_count != 0) @(posedge clk);
    repeat (80) @(posedge clk);
    if (mismatch_count == 0 && pending_count == 0)
      $display("sorted_keyed_record_list test passed");
    else
      $display("sorted_keyed_record_list test failed");
    $finish;
  end

endmodule
